// ----- rtl/clt_pkg.sv -----
`default_nettype none
package clt_pkg;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_MOVE_AFTER = 3'd1,
        OP_MOVE_BEFORE = 3'd2,
        OP_DELETE = 3'd3,
        OP_SET_HEAD = 3'd4,
        OP_SEARCH = 3'd5
    } op_t;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;
endpackage
`default_nettype wire

// ----- rtl/circular_linked_list_table_top.sv -----
// channel | valid       | ready        | payload
// in      | in_valid    | in_ready     | operation, code
// out     | out_valid   | out_ready    | status, direction, steps, entry_total
// Sequence: S_IDLE takes the beat; a search, move, delete or set-head on a non-empty
// list then has the shared compare unit visit one entry a cycle from the head (up to
// CAPACITY entries), then up to three link-table write states (S_W1, S_W2, S_W3), one
// per cycle, then S_OUT holds the result until out_ready. An insert skips the walk.
// Reset clears control, used_reg and head/count; link memories stay as they are.
// One command at a time; in_ready is low while a command or its result is held.
`default_nettype none
module circular_linked_list_table_top #(
    parameter int CAPACITY = clt_pkg::CAPACITY_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  operation,
    input  wire logic signed [31:0] code,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic             direction,
    output logic [3:0]       steps,
    output logic [4:0]       entry_total
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef logic [AW-1:0] slot_t;
    typedef enum logic [2:0] {
        S_IDLE, S_WALK, S_W1, S_W2, S_W3, S_OUT
    } state_t;

    // link table: memories, one write port each
    logic [31:0] code_mem [CAPACITY];
    slot_t       next_mem [CAPACITY];
    slot_t       prev_mem [CAPACITY];
    logic [CAPACITY-1:0] used_reg;

    state_t      state_reg;
    slot_t       head_reg;
    logic [CW-1:0] count_reg;
    logic [2:0]  op_reg;
    logic [31:0] code_reg;
    slot_t       cur_reg, w_reg, wp_reg, wn_reg;
    logic [CW-1:0] pos_reg;
    logic [1:0]  status_reg;
    logic        dir_reg;
    logic [3:0]  steps_reg;
    slot_t       free_slot;
    logic        full;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign status      = status_reg;
    assign direction   = dir_reg;
    assign steps       = steps_reg;
    assign entry_total = 5'(count_reg);

    // lowest free slot
    always_comb
    begin
        free_slot = '0;
        full = &used_reg;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
                free_slot = slot_t'(i);
        end
    end

    // shared compare unit: current slot against the code
    logic hit;
    logic [CW-1:0] back;
    assign hit  = (code_mem[cur_reg] == code_reg);
    assign back = (pos_reg == '0) ? '0 : count_reg - pos_reg;

    // single writer per memory in the write cycles
    slot_t head_next_of, head_prev_of;
    assign head_next_of = next_mem[head_reg];
    assign head_prev_of = prev_mem[head_reg];

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && operation == clt_pkg::OP_INSERT && !full)
            code_mem[free_slot] <= code;
        if (state_reg == S_W1)
        begin
            // detach or link step 1
            if (op_reg == clt_pkg::OP_INSERT)
            begin
                next_mem[w_reg] <= (count_reg == '0) ? w_reg : head_reg;
                prev_mem[w_reg] <= (count_reg == '0) ? w_reg : head_prev_of;
            end
            else
            begin
                next_mem[wp_reg] <= wn_reg;
                prev_mem[wn_reg] <= wp_reg;
            end
        end
        if (state_reg == S_W2)
        begin
            if (op_reg == clt_pkg::OP_MOVE_AFTER)
            begin
                prev_mem[w_reg] <= head_reg;
                next_mem[w_reg] <= head_next_of;
            end
            else if (op_reg == clt_pkg::OP_MOVE_BEFORE)
            begin
                prev_mem[w_reg] <= head_prev_of;
                next_mem[w_reg] <= head_reg;
            end
            else if (op_reg == clt_pkg::OP_INSERT)
                next_mem[wp_reg] <= w_reg;
        end
        if (state_reg == S_W3)
        begin
            // w already holds its own links; close the neighbours
            next_mem[prev_mem[w_reg]] <= w_reg;
            prev_mem[next_mem[w_reg]] <= w_reg;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg <= '0;
            count_reg <= '0;
            used_reg <= '0;
            status_reg <= clt_pkg::ST_OK;
            dir_reg <= 1'b0;
            steps_reg <= '0;
            op_reg <= '0;
            code_reg <= '0;
            cur_reg <= '0;
            w_reg <= '0;
            wp_reg <= '0;
            wn_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg <= operation;
                        code_reg <= code;
                        cur_reg <= head_reg;
                        pos_reg <= '0;
                        status_reg <= clt_pkg::ST_OK;
                        dir_reg <= 1'b0;
                        steps_reg <= '0;
                        if (operation == clt_pkg::OP_INSERT)
                        begin
                            if (full)
                            begin
                                status_reg <= clt_pkg::ST_FULL;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                w_reg <= free_slot;
                                wp_reg <= prev_mem[head_reg];
                                used_reg[free_slot] <= 1'b1;
                                state_reg <= S_W1;
                            end
                        end
                        else if (operation > clt_pkg::OP_SEARCH)
                            state_reg <= S_OUT;
                        else if (count_reg == '0)
                        begin
                            status_reg <= (operation == clt_pkg::OP_SEARCH) ?
                                clt_pkg::ST_EMPTY : clt_pkg::ST_NOT_FOUND;
                            state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    if (hit)
                    begin
                        w_reg <= cur_reg;
                        wp_reg <= prev_mem[cur_reg];
                        wn_reg <= next_mem[cur_reg];
                        state_reg <= S_OUT;
                        case (op_reg)
                            clt_pkg::OP_MOVE_AFTER:
                                if (cur_reg != head_reg && head_next_of != cur_reg)
                                    state_reg <= S_W1;
                            clt_pkg::OP_MOVE_BEFORE:
                                if (cur_reg != head_reg && head_prev_of != cur_reg)
                                    state_reg <= S_W1;
                            clt_pkg::OP_DELETE:
                            begin
                                used_reg[cur_reg] <= 1'b0;
                                count_reg <= count_reg - 1'b1;
                                if (count_reg == CW'(1))
                                    head_reg <= '0;
                                else
                                begin
                                    if (cur_reg == head_reg)
                                        head_reg <= next_mem[cur_reg];
                                    state_reg <= S_W1;
                                end
                            end
                            clt_pkg::OP_SET_HEAD:
                                head_reg <= cur_reg;
                            default:
                            begin
                                if (pos_reg <= back)
                                    steps_reg <= 4'(pos_reg);
                                else
                                begin
                                    dir_reg <= 1'b1;
                                    steps_reg <= 4'(back);
                                end
                            end
                        endcase
                    end
                    else if (pos_reg + 1'b1 >= count_reg)
                    begin
                        status_reg <= clt_pkg::ST_NOT_FOUND;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        cur_reg <= next_mem[cur_reg];
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
                S_W1:
                begin
                    if (op_reg == clt_pkg::OP_DELETE)
                        state_reg <= S_OUT;
                    else if (op_reg == clt_pkg::OP_INSERT && count_reg == '0)
                    begin
                        head_reg <= w_reg;
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_W2;
                end
                S_W2:
                begin
                    if (op_reg == clt_pkg::OP_INSERT)
                    begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_W3;
                    end
                    else
                        state_reg <= S_W3;
                end
                S_W3:
                    state_reg <= S_OUT;
                S_OUT:
                    if (out_ready)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // assertions
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY)) else $error("entry count above capacity");
    a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> $countones(used_reg) == int'(count_reg))
        else $error("used bits disagree with count");
    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == clt_pkg::ST_FULL) |-> count_reg == CW'(CAPACITY))
        else $error("full reported with free slot");
    a_dir_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != clt_pkg::ST_OK) |-> (direction == 1'b0 && steps == '0))
        else $error("search fields set on failure");
endmodule
`default_nettype wire
